// ===== rtl/core/rdq_pkg.sv =====
// ----------------------------------------------------------------------------
// rdq_pkg
// Types, field widths and codes shared by the ring deque files.
// ----------------------------------------------------------------------------
package rdq_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W    = 3;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK       = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OW_FRONT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OW_BACK  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
  } rdq_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] data;
    logic               data_valid;
    logic               accepted;
    logic [COUNT_W-1:0] element_count;
    logic               empty_res;
    logic               full_res;
  } rdq_out_t;

endpackage

// ===== rtl/core/rdq_ram.sv =====
// ----------------------------------------------------------------------------
// rdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/rdq_mod.sv =====
// ----------------------------------------------------------------------------
// rdq_mod
// Shift-subtract remainder unit: index modulo count, one bit per cycle.
// ----------------------------------------------------------------------------
module rdq_mod import rdq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [INDEX_W-1:0] dividend,
  input  logic [COUNT_W-1:0] divisor,
  output logic               busy,
  output logic               done,
  output logic [COUNT_W-1:0] rem
);

  localparam int CW = $clog2(INDEX_W + 1);

  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [INDEX_W-1:0] dvd_r;
  logic [COUNT_W-1:0] div_r;
  logic [CW-1:0]      cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [COUNT_W:0]   trial;

  // trial stays below twice the divisor, so one subtract restores it
  always_comb begin
    trial = {rem_r, dvd_r[INDEX_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = COUNT_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(INDEX_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[INDEX_W-2:0], 1'b0};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/core/ring_deque_with_overwrite.sv =====
// ----------------------------------------------------------------------------
// ring_deque_with_overwrite
// Double-ended ring buffer, capacity set by register, optional overwrite.
// Pushes, no-ops and reads of an empty buffer go from execute to output; pops
// add a RAM read state, and a peek first waits on the bit-serial remainder
// unit. One transaction at a time: the next is taken in the cycle after the
// result is taken. Sync reset clears pointers and count and restores the
// registers; the element storage is not cleared.
// ----------------------------------------------------------------------------
module ring_deque_with_overwrite import rdq_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rdq_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rdq_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PW = $clog2(DEPTH);
  localparam int XW = ((PW > COUNT_W) ? PW : COUNT_W) + 1;
  localparam int SW = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int CAP_RST_I = (DEPTH < 64) ? DEPTH : 64;
  localparam logic [COUNT_W-1:0] CAP_RST = COUNT_W'(CAP_RST_I);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_RD   = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [PW-1:0]       front_r, front_nxt;
  logic [PW-1:0]       back_r, back_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [COUNT_W-1:0]  capacity_r;
  logic                ow_front_r;
  logic                ow_back_r;
  rdq_out_t            out_r, out_nxt;

  logic [OP_W-1:0]     op_r;
  logic [SW-1:0]       val_r;
  logic [INDEX_W-1:0]  idx_r;

  logic [COUNT_W-1:0]  cap;
  logic [XW-1:0]       cap_x;
  logic [XW-1:0]       f_x, b_x, pk_x;
  logic [COUNT_W-1:0]  c_w;
  logic                is_full;

  logic                ram_we;
  logic [PW-1:0]       ram_waddr;
  logic [PW-1:0]       ram_raddr;
  logic [SW-1:0]       ram_rdata;

  logic                mod_start;
  logic                mod_busy;
  logic                mod_done;
  logic [COUNT_W-1:0]  mod_rem;

  function automatic logic [XW-1:0] pos_inc(input logic [XW-1:0] p, input logic [XW-1:0] c);
    return ((p + 1'b1) >= c) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [XW-1:0] pos_dec(input logic [XW-1:0] p, input logic [XW-1:0] c);
    return (p == '0 || p >= c) ? c - 1'b1 : p - 1'b1;
  endfunction

  // capacity 0 acts as 1, above DEPTH acts as DEPTH
  always_comb begin
    if (capacity_r == '0) begin
      cap = COUNT_W'(1);
    end else if (int'(capacity_r) > DEPTH) begin
      cap = COUNT_W'(DEPTH);
    end else begin
      cap = capacity_r;
    end
  end
  assign cap_x = XW'(cap);

  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    back_nxt  = back_r;
    count_nxt = count_r;
    out_nxt   = out_r;
    ram_we    = 1'b0;
    ram_waddr = back_r;
    ram_raddr = front_r;
    mod_start = 1'b0;

    f_x = (XW'(front_r) >= cap_x) ? '0 : XW'(front_r);
    b_x = (XW'(back_r) >= cap_x) ? '0 : XW'(back_r);
    c_w = (count_r > cap) ? '0 : count_r;
    is_full = (c_w >= cap);
    pk_x = XW'(front_r) + XW'(mod_rem);
    if (pk_x >= cap_x) begin
      pk_x = pk_x - cap_x;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        out_nxt   = '0;
        state_nxt = ST_OUT;
        case (op_r)
          OP_PUSH_BACK: begin
            if (!is_full || ow_front_r) begin
              if (is_full) begin
                f_x = pos_inc(f_x, cap_x);
                c_w = c_w - 1'b1;
              end
              ram_we    = 1'b1;
              ram_waddr = b_x[PW-1:0];
              b_x = pos_inc(b_x, cap_x);
              c_w = c_w + 1'b1;
              out_nxt.accepted = 1'b1;
            end
          end
          OP_PUSH_FRONT: begin
            if (!is_full || ow_back_r) begin
              if (is_full) begin
                b_x = pos_dec(b_x, cap_x);
                c_w = c_w - 1'b1;
              end
              f_x = pos_dec(f_x, cap_x);
              ram_we    = 1'b1;
              ram_waddr = f_x[PW-1:0];
              c_w = c_w + 1'b1;
              out_nxt.accepted = 1'b1;
            end
          end
          OP_POP_FRONT: begin
            if (c_w != '0) begin
              ram_raddr = f_x[PW-1:0];
              f_x = pos_inc(f_x, cap_x);
              c_w = c_w - 1'b1;
              out_nxt.data_valid = 1'b1;
              state_nxt = ST_RD;
            end
          end
          OP_POP_BACK: begin
            if (c_w != '0) begin
              b_x = pos_dec(b_x, cap_x);
              ram_raddr = b_x[PW-1:0];
              c_w = c_w - 1'b1;
              out_nxt.data_valid = 1'b1;
              state_nxt = ST_RD;
            end
          end
          OP_PEEK: begin
            if (c_w != '0) begin
              mod_start = 1'b1;
              out_nxt.data_valid = 1'b1;
              state_nxt = ST_DIV;
            end
          end
          default: begin
          end
        endcase
        front_nxt = f_x[PW-1:0];
        back_nxt  = b_x[PW-1:0];
        count_nxt = c_w;
        out_nxt.element_count = c_w;
        out_nxt.empty_res     = (c_w == '0);
        out_nxt.full_res      = (c_w == cap);
      end
      ST_DIV: begin
        if (mod_done) begin
          ram_raddr = pk_x[PW-1:0];
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        out_nxt.data = VALUE_W'(ram_rdata);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      front_r    <= '0;
      back_r     <= '0;
      count_r    <= '0;
      capacity_r <= CAP_RST;
      ow_front_r <= 1'b0;
      ow_back_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CAPACITY: begin
            capacity_r <= cfg_wdata;
            front_r    <= '0;
            back_r     <= '0;
            count_r    <= '0;
          end
          CFG_OW_FRONT: ow_front_r <= cfg_wdata[0];
          CFG_OW_BACK:  ow_back_r  <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (in_valid && !in_stall) begin
      op_r  <= in_data.op;
      val_r <= in_data.value[SW-1:0];
      idx_r <= in_data.index;
    end
  end

  rdq_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (val_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rdq_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (idx_r),
    .divisor  (c_w),
    .busy     (mod_busy),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = out_r;

  // count never runs past the effective capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap)
    else $error("count exceeds capacity");

  // the remainder unit only runs while the sequencer waits on it
  a_mod_div: assert property (@(posedge clk) disable iff (!rst_n)
    mod_busy |-> (state_r == ST_DIV))
    else $error("remainder unit busy outside divide state");

  // an accepted transaction is executed in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_EXEC))
    else $error("accepted transaction not executed");

  // no data shown without data_valid
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_r.data_valid || out_r.data == '0))
    else $error("data nonzero while data_valid low");

endmodule
